@@ hdl/thr_pkg.sv @@
package thr_pkg;

	// request function codes
	localparam logic FUNC_LOG  = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	// bytes in one telemetry record
	localparam int RECORD_BYTES = 7;
	localparam int CNT_W        = $clog2(RECORD_BYTES);

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_APPEND,
		ST_REDUCE,
		ST_READ
	} thr_state_t;

	// read issue control handed from sequencer to output side
	typedef struct packed {
		logic fire;
		logic live;
	} thr_rd_t;

endpackage

@@ hdl/thr_ram.sv @@
module thr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 224
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/thr_seq.sv @@
module thr_seq #(
	parameter int DEPTH = 224
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     func,
	input  logic [7:0]               batt_temp,
	input  logic [7:0]               power_temp,
	input  logic [7:0]               radio_temp,
	input  logic [7:0]               bus5_current,
	input  logic [7:0]               bus33_current,
	input  logic [7:0]               batt_current,
	input  logic [7:0]               batt_voltage,
	input  logic [7:0]               age,
	input  logic                     slot_free,
	output logic                     mem_we,
	output logic [$clog2(DEPTH)-1:0] mem_waddr,
	output logic [7:0]               mem_wdata,
	output logic                     mem_re,
	output logic [$clog2(DEPTH)-1:0] mem_raddr,
	output thr_pkg::thr_rd_t         rd
);

	import thr_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = (PW > 8) ? PW + 1 : 9;

	thr_state_t       state_q, state_d;
	logic [PW-1:0]    wp_q;
	logic             wrapped_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       rec_q [RECORD_BYTES];
	logic [7:0]       age_q;

	logic             accept;
	logic             age_big;
	logic             last_byte;
	logic [CW-1:0]    addr_sum;
	logic [CW-1:0]    addr_wrap;
	logic [PW-1:0]    rd_addr;

	assign accept    = in_valid && !in_stall;
	assign age_big   = CW'(age_q) >= CW'(DEPTH);
	assign last_byte = cnt_q == CNT_W'(RECORD_BYTES - 1);

	// newest byte sits one behind the write pointer; step back by the reduced age
	assign addr_sum  = CW'(wp_q) + CW'(DEPTH - 1) - CW'(PW'(age_q));
	assign addr_wrap = (addr_sum >= CW'(DEPTH)) ? addr_sum - CW'(DEPTH) : addr_sum;
	assign rd_addr   = PW'(addr_wrap);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (func == FUNC_READ) ? ST_REDUCE : ST_APPEND;
				end
			end
			ST_APPEND: begin
				if (last_byte) begin
					state_d = ST_IDLE;
				end
			end
			ST_REDUCE: begin
				if (!age_big) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall  = 1'b1;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		rd.fire   = 1'b0;
		// entries past the fill point were never written; live is low for them
		rd.live   = wrapped_q || (rd_addr < wp_q);
		unique case (state_q)
			ST_IDLE:   in_stall = 1'b0;
			ST_APPEND: mem_we   = 1'b1;
			ST_REDUCE: in_stall = 1'b1;
			ST_READ: begin
				mem_re  = slot_free;
				rd.fire = slot_free;
			end
			default: in_stall = 1'b1;
		endcase
	end

	assign mem_waddr = wp_q;
	assign mem_wdata = rec_q[0];
	assign mem_raddr = rd_addr;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == ST_APPEND) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (wp_q == PW'(DEPTH - 1)) begin
					wp_q      <= '0;
					wrapped_q <= 1'b1;
				end else begin
					wp_q <= wp_q + PW'(1);
				end
			end
		end
	end

	// record bytes shift out battery temperature first; age folds down by the depth
	always_ff @(posedge clk) begin
		if (accept) begin
			rec_q[0] <= batt_temp;
			rec_q[1] <= power_temp;
			rec_q[2] <= radio_temp;
			rec_q[3] <= bus5_current;
			rec_q[4] <= bus33_current;
			rec_q[5] <= batt_current;
			rec_q[6] <= batt_voltage;
			age_q    <= age;
		end else begin
			if (state_q == ST_APPEND) begin
				for (int i = 0; i < RECORD_BYTES - 1; i++) begin
					rec_q[i] <= rec_q[i+1];
				end
			end
			if (state_q == ST_REDUCE && age_big) begin
				age_q <= 8'(CW'(age_q) - CW'(DEPTH));
			end
		end
	end

endmodule

@@ hdl/telemetry_history_ring.sv @@
// Circular history of housekeeping telemetry bytes, DEPTH bytes deep, held in
// one byte-wide synchronous RAM. A log request (func 0) appends its seven
// readings at the write pointer, battery temperature first and battery voltage
// last, and gives no result; after capturing the record it stalls the input
// while it writes the bytes one at a time through the single RAM write port. A
// read request (func 1) returns the byte age positions behind the newest byte,
// ages beyond the depth wrapping around; after capturing the request it stalls
// the input while it checks the age, subtracts the depth as often as it takes
// to fold the age down, waits for a free output register and issues the RAM
// read. The RAM output and the read in flight are registered, and read_byte is
// registered from them in turn. The store reads as zero after reset without a
// clearing pass: a fill mark on the write pointer tells which entries were
// never written.
module telemetry_history_ring #(
	parameter int DEPTH = 224
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       func,
	input  logic [7:0] batt_temp,
	input  logic [7:0] power_temp,
	input  logic [7:0] radio_temp,
	input  logic [7:0] bus5_current,
	input  logic [7:0] bus33_current,
	input  logic [7:0] batt_current,
	input  logic [7:0] batt_voltage,
	input  logic [7:0] age,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_byte
);

	import thr_pkg::*;

	localparam int PW = $clog2(DEPTH);

	logic          mem_we;
	logic [PW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [PW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;
	thr_rd_t       rd;
	thr_rd_t       rd_s1;
	logic          slot_free;
	logic          out_valid_q;
	logic [7:0]    read_byte_q;

	// a read may issue only if the output register is free when its data lands
	assign slot_free = !rd_s1.fire && (!out_valid_q || !out_stall);

	thr_seq #(
		.DEPTH(DEPTH)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.batt_temp    (batt_temp),
		.power_temp   (power_temp),
		.radio_temp   (radio_temp),
		.bus5_current (bus5_current),
		.bus33_current(bus33_current),
		.batt_current (batt_current),
		.batt_voltage (batt_voltage),
		.age          (age),
		.slot_free    (slot_free),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.rd           (rd)
	);

	thr_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// track the read in flight and the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1 <= rd;
			if (rd_s1.fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output data, zero for entries never written
	always_ff @(posedge clk) begin
		if (rd_s1.fire) begin
			read_byte_q <= rd_s1.live ? mem_rdata : 8'h00;
		end
	end

	assign out_valid = out_valid_q;
	assign read_byte = read_byte_q;

endmodule
